/* src/vvwt_pkg.sv */
// Package: shared types and constants for the version vote window tracker.
`default_nettype none
package vvwt_pkg;
    localparam int MAX_ENTRIES   = 16;
    localparam int ENTRY_W       = 4;
    localparam int COUNT_W       = 5;
    localparam int WINDOW_MAX    = 16384;
    localparam int RING_AW       = 14;
    localparam int FILL_W        = 15;
    localparam int VERSION_COUNT = 256;
    localparam int TALLY_AW      = 8;
    localparam int TALLY_W       = 15;

    localparam logic [1:0] MODE_ADD_ENTRY = 2'd0;
    localparam logic [1:0] MODE_ADD_BLOCK = 2'd1;
    localparam logic [1:0] MODE_CHECK_NOW = 2'd2;
    localparam logic [1:0] MODE_CHECK_AT  = 2'd3;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_RULE = 2'd1;
    localparam logic [1:0] STAT_FULL = 2'd2;

    localparam logic [1:0] CFG_WINDOW_LENGTH   = 2'd0;
    localparam logic [1:0] CFG_DEFAULT_PERCENT = 2'd1;
    localparam logic [1:0] CFG_BASE_VERSION    = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  version;
        logic [7:0]  vote;
        logic [47:0] height;
        logic [6:0]  percent;
        logic        use_default;
        logic [31:0] entry_time;
    } in_item_t;

    typedef struct packed {
        logic        accepted;
        logic [1:0]  status;
        logic [7:0]  recorded_version;
        logic [7:0]  active_version;
        logic [3:0]  current_entry;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_EV_RD, ST_EV_TL, ST_EV_DEC, ST_PUSH, ST_INC,
        ST_WALK_RD, ST_WALK_ACC, ST_WALK_CMP, ST_FIN
    } state_t;
endpackage
`default_nettype wire

/* src/vvwt_ram.sv */
// Generic single-port-write, registered-read RAM used for the vote ring.
`default_nettype none
module vvwt_ram #(
    parameter int AW = 14,
    parameter int DW = 8
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);
    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* src/vvwt_tally.sv */
// Per-version vote count store with valid bits so it reads zero after reset.
`default_nettype none
module vvwt_tally (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         we,
    input  wire logic [vvwt_pkg::TALLY_AW-1:0] waddr,
    input  wire logic [vvwt_pkg::TALLY_W-1:0]  wdata,
    input  wire logic [vvwt_pkg::TALLY_AW-1:0] raddr,
    output logic      [vvwt_pkg::TALLY_W-1:0]  rdata
);
    import vvwt_pkg::*;

    logic [TALLY_W-1:0]       mem [VERSION_COUNT];
    logic [VERSION_COUNT-1:0] valid_reg;
    logic [TALLY_W-1:0]       rd_reg;
    logic                     rv_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            rv_reg    <= 1'b0;
        end else begin
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
            rv_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rv_reg ? rd_reg : '0;
endmodule
`default_nettype wire

/* src/version_vote_window_tracker_top.sv */
// Top level: upgrade table, vote window sequencer and result register.
`default_nettype none
// Version vote window tracker. One item is taken at a time; s_ready is high
// only while the sequencer idles. Mode 0 (add entry) and mode 2 (check now)
// go from the check state straight to the final state, which loads the
// result register. Mode 1 (add block) drops each vote that leaves the
// window (ring read, tally read, tally write), pushes the new vote and
// raises its count, then walks the table entries (tally read, accumulate,
// threshold compare), up to 15 entries. Mode 3 walks the table the same
// way. After the window was shrunk, one item can drop more than one vote. A
// stalled result register holds the sequencer in its final state until the
// result leaves. A finished result sits in the m_ register while the next
// item is accepted. The count store reads zero after reset through per-slot
// valid bits, so there is no clearing pass. Config is written through
// cfg_wr_en/cfg_index/cfg_wdata and must only change while the block is idle.
module version_vote_window_tracker_top (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [14:0]         cfg_wdata,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire vvwt_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output vvwt_pkg::out_item_t      m_data
);
    import vvwt_pkg::*;

    // config registers
    logic [14:0] win_len_reg;
    logic [6:0]  def_pct_reg;
    logic [7:0]  base_ver_reg;

    // upgrade table
    logic [7:0]  entry_ver_reg [MAX_ENTRIES];
    logic [47:0] entry_h_reg   [MAX_ENTRIES];
    logic [6:0]  entry_pct_reg [MAX_ENTRIES];
    logic        entry_we;
    logic [6:0]  entry_pct_w;

    state_t state_reg, state_next;
    in_item_t in_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [31:0] time_reg, time_next;
    logic [7:0]  newest_ver_reg, newest_ver_next;
    logic [47:0] last_h_reg, last_h_next;
    logic [ENTRY_W-1:0] active_reg, active_next;
    logic [7:0]  active_ver_reg, active_ver_next;
    logic [RING_AW-1:0] oldest_reg, oldest_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;

    // per-item working registers
    logic [7:0]  vclamp_reg, vclamp_next;
    logic [48:0] hcmp_reg, hcmp_next;
    logic [TALLY_AW-1:0] ev_slot_reg, ev_slot_next;
    logic [15:0] acc_reg, acc_next;
    logic [ENTRY_W-1:0] walk_n_reg, walk_n_next;
    logic        found_reg, found_next;
    logic [ENTRY_W-1:0] got_idx_reg, got_idx_next;
    logic [7:0]  got_ver_reg, got_ver_next;
    logic        acc_res_reg, acc_res_next;
    logic [1:0]  stat_reg, stat_next;
    logic [7:0]  rec_reg, rec_next;

    logic        m_valid_reg, m_valid_next;
    out_item_t   m_data_reg, m_data_next;

    // ring and tally ports
    logic               ring_we;
    logic [RING_AW-1:0] ring_waddr, ring_raddr;
    logic [7:0]         ring_rdata;
    logic               tally_we;
    logic [TALLY_AW-1:0] tally_waddr, tally_raddr;
    logic [TALLY_W-1:0]  tally_wdata, tally_rdata;

    vvwt_ram #(.AW(RING_AW), .DW(8)) u_ring (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (vclamp_reg),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    vvwt_tally u_tally (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (tally_we),
        .waddr   (tally_waddr),
        .wdata   (tally_wdata),
        .raddr   (tally_raddr),
        .rdata   (tally_rdata)
    );

    // derived values
    logic [FILL_W-1:0] win_eff;
    logic [7:0] cur_ver, newest_ver, vote_eff;
    logic       blk_ok, walk_hit, out_free;
    logic [7:0] ev_n, ev3;
    logic [47:0] eh_n;
    logic [6:0]  ep_n;
    logic [22:0] have_x100, need_x100;

    always_comb begin
        if (win_len_reg == '0) begin
            win_eff = FILL_W'(1);
        end else if (win_len_reg > FILL_W'(WINDOW_MAX)) begin
            win_eff = FILL_W'(WINDOW_MAX);
        end else begin
            win_eff = win_len_reg;
        end
    end

    assign cur_ver    = (count_reg == '0) ? base_ver_reg : active_ver_reg;
    assign newest_ver = (count_reg == '0) ? base_ver_reg : newest_ver_reg;
    assign vote_eff   = (in_reg.vote == 8'd0) ? 8'd1 : in_reg.vote;
    assign blk_ok     = (in_reg.version == cur_ver) && (vote_eff >= cur_ver);
    assign ev_n       = entry_ver_reg[walk_n_reg];
    assign eh_n       = entry_h_reg[walk_n_reg];
    assign ep_n       = entry_pct_reg[walk_n_reg];
    // acc >= ceil(W*pct/100) is the same test as acc*100 >= W*pct
    assign have_x100  = {7'd0, acc_reg} * 23'd100;
    assign need_x100  = {8'd0, win_eff} * {16'd0, ep_n};
    assign walk_hit   = (hcmp_reg >= {1'b0, eh_n}) && (have_x100 >= need_x100);
    assign ev3        = found_reg ? got_ver_reg : cur_ver;
    assign out_free   = !m_valid_reg || m_ready;
    assign entry_pct_w = in_reg.use_default ? def_pct_reg : in_reg.percent;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                case (in_reg.mode)
                    MODE_ADD_BLOCK: begin
                        if (!blk_ok) state_next = ST_FIN;
                        else if (fill_reg >= win_eff) state_next = ST_EV_RD;
                        else state_next = ST_PUSH;
                    end
                    MODE_CHECK_AT: begin
                        state_next = (count_reg >= COUNT_W'(2)) ? ST_WALK_RD : ST_FIN;
                    end
                    default: state_next = ST_FIN;
                endcase
            end
            ST_EV_RD:  state_next = ST_EV_TL;
            ST_EV_TL:  state_next = ST_EV_DEC;
            ST_EV_DEC: begin
                state_next = ((fill_reg - FILL_W'(1)) >= win_eff) ? ST_EV_RD : ST_PUSH;
            end
            ST_PUSH:   state_next = ST_INC;
            ST_INC: begin
                state_next = (count_reg >= COUNT_W'(2)) ? ST_WALK_RD : ST_FIN;
            end
            ST_WALK_RD:  state_next = ST_WALK_ACC;
            ST_WALK_ACC: state_next = ST_WALK_CMP;
            ST_WALK_CMP: begin
                state_next = (walk_hit || walk_n_reg == ENTRY_W'(1)) ? ST_FIN : ST_WALK_RD;
            end
            ST_FIN: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        logic bad;
        logic upd;
        bad             = 1'b0;
        upd             = 1'b0;
        count_next      = count_reg;
        time_next       = time_reg;
        newest_ver_next = newest_ver_reg;
        last_h_next     = last_h_reg;
        active_next     = active_reg;
        active_ver_next = active_ver_reg;
        oldest_next     = oldest_reg;
        fill_next       = fill_reg;
        vclamp_next     = vclamp_reg;
        hcmp_next       = hcmp_reg;
        ev_slot_next    = ev_slot_reg;
        acc_next        = acc_reg;
        walk_n_next     = walk_n_reg;
        found_next      = found_reg;
        got_idx_next    = got_idx_reg;
        got_ver_next    = got_ver_reg;
        acc_res_next    = acc_res_reg;
        stat_next       = stat_reg;
        rec_next        = rec_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        entry_we        = 1'b0;
        ring_we         = 1'b0;
        ring_waddr      = oldest_reg + fill_reg[RING_AW-1:0];
        ring_raddr      = oldest_reg;
        tally_we        = 1'b0;
        tally_waddr     = ev_slot_reg;
        tally_wdata     = (tally_rdata == '0) ? '0 : tally_rdata - TALLY_W'(1);
        tally_raddr     = ev_n;

        case (state_reg)
            ST_CHECK: begin
                found_next   = 1'b0;
                acc_next     = '0;
                walk_n_next  = ENTRY_W'(count_reg - COUNT_W'(1));
                acc_res_next = 1'b0;
                stat_next    = STAT_RULE;
                rec_next     = 8'd0;
                hcmp_next    = {1'b0, in_reg.height};
                case (in_reg.mode)
                    MODE_ADD_ENTRY: begin
                        bad = (in_reg.version == 8'd0) || (entry_pct_w > 7'd100);
                        if (count_reg != '0) begin
                            if (in_reg.version <= newest_ver_reg ||
                                in_reg.height <= last_h_reg ||
                                in_reg.entry_time <= time_reg) begin
                                bad = 1'b1;
                            end
                        end
                        if (bad) begin
                            stat_next = STAT_RULE;
                        end else if (count_reg >= COUNT_W'(MAX_ENTRIES)) begin
                            stat_next = STAT_FULL;
                        end else begin
                            entry_we        = 1'b1;
                            count_next      = count_reg + COUNT_W'(1);
                            time_next       = in_reg.entry_time;
                            newest_ver_next = in_reg.version;
                            last_h_next     = in_reg.height;
                            if (count_reg == '0) active_ver_next = in_reg.version;
                            acc_res_next    = 1'b1;
                            stat_next       = STAT_OK;
                        end
                    end
                    MODE_ADD_BLOCK: begin
                        if (blk_ok) begin
                            acc_res_next = 1'b1;
                            stat_next    = STAT_OK;
                            rec_next     = cur_ver;
                            vclamp_next  = (vote_eff > newest_ver) ? newest_ver : vote_eff;
                            hcmp_next    = {1'b0, in_reg.height} + 49'd1;
                        end
                    end
                    MODE_CHECK_NOW: begin
                        if (blk_ok) begin
                            acc_res_next = 1'b1;
                            stat_next    = STAT_OK;
                        end
                    end
                    default: ;
                endcase
            end
            ST_EV_TL: begin
                tally_raddr  = ring_rdata;
                ev_slot_next = ring_rdata;
            end
            ST_EV_DEC: begin
                tally_we    = 1'b1;
                oldest_next = oldest_reg + RING_AW'(1);
                fill_next   = fill_reg - FILL_W'(1);
            end
            ST_PUSH: begin
                ring_we     = 1'b1;
                tally_raddr = vclamp_reg;
                fill_next   = fill_reg + FILL_W'(1);
            end
            ST_INC: begin
                tally_we    = 1'b1;
                tally_waddr = vclamp_reg;
                tally_wdata = tally_rdata + TALLY_W'(1);
            end
            ST_WALK_ACC: begin
                acc_next = acc_reg + {1'b0, tally_rdata};
            end
            ST_WALK_CMP: begin
                if (walk_hit) begin
                    found_next   = 1'b1;
                    got_idx_next = walk_n_reg;
                    got_ver_next = ev_n;
                end else begin
                    walk_n_next = walk_n_reg - ENTRY_W'(1);
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next.accepted         = acc_res_reg;
                    m_data_next.status           = stat_reg;
                    m_data_next.recorded_version = rec_reg;
                    m_data_next.active_version   = cur_ver;
                    m_data_next.current_entry    = active_reg;
                    if (in_reg.mode == MODE_CHECK_AT) begin
                        if (in_reg.version == ev3 && vote_eff >= ev3) begin
                            m_data_next.accepted = 1'b1;
                            m_data_next.status   = STAT_OK;
                        end
                    end
                    upd = (in_reg.mode == MODE_ADD_BLOCK) && found_reg &&
                          (got_idx_reg > active_reg);
                    if (upd) begin
                        active_next     = got_idx_reg;
                        active_ver_next = got_ver_reg;
                        m_data_next.active_version = got_ver_reg;
                        m_data_next.current_entry  = got_idx_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            win_len_reg    <= 15'd1024;
            def_pct_reg    <= 7'd0;
            base_ver_reg   <= 8'd1;
            count_reg      <= '0;
            time_reg       <= '0;
            active_reg     <= '0;
            oldest_reg     <= '0;
            fill_reg       <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            time_reg    <= time_next;
            active_reg  <= active_next;
            oldest_reg  <= oldest_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_WINDOW_LENGTH:   win_len_reg  <= cfg_wdata;
                    CFG_DEFAULT_PERCENT: def_pct_reg  <= cfg_wdata[6:0];
                    CFG_BASE_VERSION:    base_ver_reg <= cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            in_reg <= s_data;
        end
        if (entry_we) begin
            entry_ver_reg[count_reg[ENTRY_W-1:0]] <= in_reg.version;
            entry_h_reg[count_reg[ENTRY_W-1:0]]   <= in_reg.height;
            entry_pct_reg[count_reg[ENTRY_W-1:0]] <= entry_pct_w;
        end
        newest_ver_reg <= newest_ver_next;
        last_h_reg     <= last_h_next;
        active_ver_reg <= active_ver_next;
        vclamp_reg     <= vclamp_next;
        hcmp_reg       <= hcmp_next;
        ev_slot_reg    <= ev_slot_next;
        acc_reg        <= acc_next;
        walk_n_reg     <= walk_n_next;
        found_reg      <= found_next;
        got_idx_reg    <= got_idx_next;
        got_ver_reg    <= got_ver_next;
        acc_res_reg    <= acc_res_next;
        stat_reg       <= stat_next;
        rec_reg        <= rec_next;
        m_data_reg     <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // window never holds more votes than the ring
    a_fill_max: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(WINDOW_MAX))
        else $error("vote window overfilled");

    // table never grows past its depth
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(MAX_ENTRIES))
        else $error("upgrade table overfilled");

    // entry in force always lies inside the table
    a_active_in: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != '0 |-> {1'b0, active_reg} < count_reg)
        else $error("active entry beyond table");

    // accepted results always carry an ok status, and only they do
    a_acc_stat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.accepted == (m_data_reg.status == STAT_OK)))
        else $error("accepted and status disagree");
endmodule
`default_nettype wire

/* test/vvwt_checker.sv */
// Checker: predicts the tracker's results from the observed items and compares them.
`default_nettype none
module vvwt_checker (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [1:0]          cfg_index,
    input  wire logic [14:0]         cfg_wdata,
    input  wire logic                s_valid,
    input  wire logic                s_ready,
    input  wire vvwt_pkg::in_item_t  s_data,
    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire vvwt_pkg::out_item_t m_data,
    output int                       fail_count,
    output int                       pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import vvwt_pkg::*;

    // shadow configuration
    int unsigned win_len, def_pct, base_ver;
    // shadow table and vote window
    logic [7:0]      tbl_ver[MAX_ENTRIES];
    longint unsigned tbl_h[MAX_ENTRIES];
    int unsigned     tbl_pct[MAX_ENTRIES];
    int unsigned     tbl_cnt, newest_t;
    logic [7:0]      ring[WINDOW_MAX];
    int unsigned     ring_head, ring_fill;
    int unsigned     tally[VERSION_COUNT];
    int unsigned     cur_idx;

    out_item_t result_q[$];

    function automatic int unsigned window_len_eff();
        if (win_len == 0) return 1;
        if (win_len > WINDOW_MAX) return WINDOW_MAX;
        return win_len;
    endfunction

    function automatic int unsigned ver_of(int unsigned idx);
        if (tbl_cnt == 0 || idx >= tbl_cnt) return base_ver;
        return tbl_ver[idx];
    endfunction

    // newest entry that has both its height and its share of the window
    function automatic int unsigned upgrade_index(longint unsigned h);
        int unsigned acc;
        int unsigned need;
        acc = 0;
        if (tbl_cnt < 2) return cur_idx;
        for (int unsigned n = tbl_cnt - 1; n > 0; n--) begin
            acc += tally[tbl_ver[n]];
            need = (window_len_eff() * tbl_pct[n] + 99) / 100;
            if (h >= tbl_h[n] && acc >= need) return n;
        end
        return cur_idx;
    endfunction

    function automatic bit block_fits(int unsigned ver, int unsigned vt, int unsigned idx);
        return ver == ver_of(idx) && vt >= ver_of(idx);
    endfunction

    task automatic predict_result(input in_item_t it, output out_item_t r);
        int unsigned vt, thr, w, nv, v, got;
        bit bad;
        r = '0;
        r.status = STAT_RULE;
        vt = (it.vote == 0) ? 1 : it.vote;
        case (it.mode)
            MODE_ADD_ENTRY: begin
                thr = it.use_default ? def_pct : it.percent;
                bad = (it.version == 0) || (thr > 100);
                if (tbl_cnt > 0 && (it.version <= tbl_ver[tbl_cnt-1] ||
                    it.height <= tbl_h[tbl_cnt-1] || it.entry_time <= newest_t))
                    bad = 1;
                if (bad) begin
                    r.status = STAT_RULE;
                end else if (tbl_cnt >= MAX_ENTRIES) begin
                    r.status = STAT_FULL;
                end else begin
                    tbl_ver[tbl_cnt] = it.version;
                    tbl_h[tbl_cnt] = it.height;
                    tbl_pct[tbl_cnt] = thr;
                    tbl_cnt++;
                    newest_t = it.entry_time;
                    r.accepted = 1;
                    r.status = STAT_OK;
                end
            end
            MODE_ADD_BLOCK: begin
                if (block_fits(it.version, vt, cur_idx)) begin
                    w = window_len_eff();
                    nv = (tbl_cnt == 0) ? base_ver : tbl_ver[tbl_cnt-1];
                    v = (vt > nv) ? nv : vt;
                    r.recorded_version = 8'(ver_of(cur_idx));
                    while (ring_fill >= w) begin
                        if (tally[ring[ring_head]] > 0) tally[ring[ring_head]]--;
                        ring_head = (ring_head + 1) % WINDOW_MAX;
                        ring_fill--;
                    end
                    ring[(ring_head + ring_fill) % WINDOW_MAX] = 8'(v);
                    ring_fill++;
                    tally[v]++;
                    got = upgrade_index(longint'(it.height) + 1);
                    if (got > cur_idx) cur_idx = got;
                    r.accepted = 1;
                    r.status = STAT_OK;
                end
            end
            MODE_CHECK_NOW: begin
                if (block_fits(it.version, vt, cur_idx)) begin
                    r.accepted = 1;
                    r.status = STAT_OK;
                end
            end
            default: begin
                if (block_fits(it.version, vt, upgrade_index(it.height))) begin
                    r.accepted = 1;
                    r.status = STAT_OK;
                end
            end
        endcase
        r.active_version = 8'(ver_of(cur_idx));
        r.current_entry = cur_idx[3:0];
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        out_item_t fresh;
        if (!aresetn) begin
            win_len = 1024; def_pct = 0; base_ver = 1;
            tbl_cnt = 0; newest_t = 0; ring_head = 0; ring_fill = 0; cur_idx = 0;
            foreach (tally[i]) tally[i] = 0;
            result_q.delete();
            fail_count <= 0;
            pending <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_WINDOW_LENGTH:   win_len = 32'(cfg_wdata);
                    CFG_DEFAULT_PERCENT: def_pct = 32'(cfg_wdata[6:0]);
                    CFG_BASE_VERSION:    base_ver = 32'(cfg_wdata[7:0]);
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    $error("result with nothing expected: %p", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = result_q[0];
                    result_q.delete(0);
                    if (want != m_data) fail_count <= fail_count + 1;
                    if (want.accepted != m_data.accepted)
                        $error("accepted: expected %0d got %0d", want.accepted, m_data.accepted);
                    if (want.status != m_data.status)
                        $error("status: expected %0d got %0d", want.status, m_data.status);
                    if (want.recorded_version != m_data.recorded_version)
                        $error("recorded_version: expected %0d got %0d",
                               want.recorded_version, m_data.recorded_version);
                    if (want.active_version != m_data.active_version)
                        $error("active_version: expected %0d got %0d",
                               want.active_version, m_data.active_version);
                    if (want.current_entry != m_data.current_entry)
                        $error("current_entry: expected %0d got %0d",
                               want.current_entry, m_data.current_entry);
                end
            end
            if (s_valid && s_ready) begin
                predict_result(s_data, fresh);
                result_q = {result_q, fresh};
            end
            pending <= result_q.size();
        end
    end
endmodule
`default_nettype wire

/* test/tb_version_vote_window_tracker_top.sv */
// Testbench top: clock, reset, stimulus, result back-pressure and verdict.
`default_nettype none
module tb_version_vote_window_tracker_top;
    timeunit 1ns;
    timeprecision 1ps;
    import vvwt_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 140;

    logic      aclk = 0;
    logic      aresetn = 0;
    logic      cfg_wr_en = 0;
    logic [1:0] cfg_index = CFG_WINDOW_LENGTH;
    logic [14:0] cfg_wdata = '0;
    logic      s_valid = 0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 0;
    out_item_t m_data;
    int        fail_count, pending;
    int        cycles = 0;
    bit        calm = 0;     // no idling on either side near the end

    // Stimulus-side view of the table, used only to build well-formed entries.
    int unsigned     top_ver, tbl_n, def_pct_tb, base_tb;
    longint unsigned top_h, blk_h;
    int unsigned     top_t;
    logic [7:0]      seen_ver = 8'd1;  // current version from the latest result

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    version_vote_window_tracker_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    vvwt_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending(pending)
    );

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_version_vote_window_tracker_top failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (m_valid && m_ready) seen_ver <= m_data.active_version;
    end

    // result side: ready and stalled in stretches of random length
    initial begin
        @(posedge aclk);
        forever begin
            m_ready <= 1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            if (!calm) begin
                m_ready <= 0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
        end
    end

    // Present one item and hold it until taken. The table shadow follows the
    // same acceptance rule as the block for entry adds.
    task automatic send_item(input in_item_t it);
        int unsigned thr;
        thr = it.use_default ? def_pct_tb : it.percent;
        if (it.mode == MODE_ADD_ENTRY && it.version != 0 && thr <= 100 && tbl_n < MAX_ENTRIES
            && (tbl_n == 0 || (it.version > top_ver && it.height > top_h
            && it.entry_time > top_t))) begin
            top_ver = it.version;
            top_h = it.height;
            top_t = it.entry_time;
            tbl_n++;
        end
        s_valid <= 1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_fields(input logic [1:0] md, input int unsigned ver, input int unsigned vt,
                               input longint unsigned h, input int unsigned pct,
                               input bit ud, input int unsigned t);
        in_item_t it;
        it.mode = md; it.version = 8'(ver); it.vote = 8'(vt); it.height = 48'(h);
        it.percent = 7'(pct); it.use_default = ud; it.entry_time = t;
        send_item(it);
    endtask

    // sender-side gap; wait_idle also lowers s_valid
    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    // wait for every result so a register can then be written
    task automatic wait_idle();
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0 || m_valid) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val[14:0];
        @(posedge aclk);
        cfg_wr_en <= 0;
        @(posedge aclk);
        if (idx == CFG_DEFAULT_PERCENT) def_pct_tb = val & 'h7f;
        if (idx == CFG_BASE_VERSION) base_tb = val & 'hff;
    endtask

    // Mostly well-formed traffic: entries that extend the table, blocks at the
    // version in force voting for newer versions. The rest is noise.
    task automatic random_item();
        int unsigned r, newest, vt;
        in_item_t it;
        r = $urandom_range(0, 99);
        newest = (tbl_n == 0) ? base_tb : top_ver;
        vt = $urandom_range(seen_ver, newest > seen_ver ? newest : seen_ver);
        if ($urandom_range(0, 9) == 0) vt = 0;
        if (r < 12) begin
            it.mode = MODE_ADD_ENTRY;
            it.version = (top_ver >= 250) ? 8'($urandom) : 8'(top_ver + $urandom_range(1, 5));
            it.height = 48'(((blk_h + 1 > top_h) ? blk_h : top_h) + $urandom_range(1, 30));
            it.vote = 8'($urandom);
            it.percent = 7'($urandom_range(0, 45));
            it.use_default = ($urandom_range(0, 3) == 0);
            it.entry_time = top_t + $urandom_range(1, 1000);
        end else if (r < 88) begin
            it.mode = (r < 70) ? MODE_ADD_BLOCK : (r < 80) ? MODE_CHECK_NOW : MODE_CHECK_AT;
            it.version = ($urandom_range(0, 9) == 0) ? 8'($urandom) : seen_ver;
            it.vote = 8'(vt);
            it.height = 48'(blk_h);
            if (it.mode == MODE_CHECK_AT && $urandom_range(0, 3) == 0)
                it.height = 48'({$urandom, $urandom});
            it.percent = 7'($urandom);
            it.use_default = 1'($urandom);
            it.entry_time = $urandom;
            blk_h += $urandom_range(0, 3);
        end else begin
            it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
        end
        send_item(it);
    endtask

    initial begin
        int unsigned windows[5];
        int unsigned pcts[5];
        windows = '{8, 0, 32767, 16384, 5};
        pcts = '{20, 100, 0, 55, 100};
        top_ver = 0; tbl_n = 0; top_h = 0; top_t = 0; blk_h = 10;
        def_pct_tb = 0; base_tb = 1;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // empty table: stand-in entry of version 1
        send_fields(MODE_ADD_BLOCK, 1, 0, 0, 0, 0, 0);          // zero vote counts as one
        send_fields(MODE_ADD_BLOCK, 2, 2, 1, 0, 0, 0);          // wrong version
        send_fields(MODE_CHECK_NOW, 1, 1, 2, 0, 0, 0);
        send_fields(MODE_CHECK_AT, 1, 255, 48'hFFFF_FFFF_FFFF, 127, 1, 32'hFFFF_FFFF);
        send_fields(MODE_ADD_ENTRY, 0, 0, 5, 10, 0, 5);         // zero version
        send_fields(MODE_ADD_ENTRY, 2, 0, 5, 101, 0, 5);        // percent too high
        wait_idle();
        write_reg(CFG_BASE_VERSION, 0);
        send_fields(MODE_ADD_BLOCK, 0, 0, 3, 0, 0, 0);          // vote clamped to zero
        send_fields(MODE_CHECK_NOW, 0, 7, 3, 0, 0, 0);
        wait_idle();
        write_reg(CFG_BASE_VERSION, 255);
        send_fields(MODE_ADD_BLOCK, 255, 255, 4, 0, 0, 0);
        send_fields(MODE_ADD_BLOCK, 255, 254, 4, 0, 0, 0);      // vote below version
        wait_idle();
        write_reg(CFG_BASE_VERSION, 1);
        write_reg(CFG_WINDOW_LENGTH, 1);
        // first entry: ordering not checked, default percent taken
        send_fields(MODE_ADD_ENTRY, 1, 0, 0, 127, 1, 0);
        send_fields(MODE_ADD_ENTRY, 1, 0, 20, 50, 0, 10);       // version not rising
        send_fields(MODE_ADD_ENTRY, 3, 0, 0, 50, 0, 10);        // height not rising
        send_fields(MODE_ADD_ENTRY, 3, 0, 20, 50, 0, 0);        // time not rising
        send_fields(MODE_ADD_ENTRY, 3, 0, 20, 100, 0, 10);
        send_fields(MODE_ADD_BLOCK, 1, 200, 19, 0, 0, 0);       // vote clamped, upgrade
        send_fields(MODE_CHECK_AT, 3, 3, 30, 0, 0, 0);
        send_fields(MODE_ADD_BLOCK, 1, 1, 20, 0, 0, 0);
        blk_h = 20;

        for (int ph = 0; ph < 5; ph++) begin
            wait_idle();
            write_reg(CFG_WINDOW_LENGTH, windows[ph]);
            write_reg(CFG_DEFAULT_PERCENT, pcts[ph]);
            if (ph == 4) calm = 1;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                maybe_gap();
                random_item();
            end
        end
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0 || m_valid) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_version_vote_window_tracker_top passed");
        end else begin
            $display("tb_version_vote_window_tracker_top failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
